// File: src/dpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpb_pkg;

   // field widths
   localparam int PIX_W    = 12;
   localparam int DEPTH_W  = 16;
   localparam int CLASS_W  = 16;
   localparam int COORD_W  = 21;
   localparam int LABEL_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int INV_W    = 24;
   localparam int CENTRE_W = 16;

   // pipeline arithmetic widths
   localparam int DIFF_W   = PIX_W + 5;                 // col*16 - centre, signed
   localparam int PROD1_W  = DIFF_W + DEPTH_W;          // diff * depth, signed
   localparam int PROD2_W  = PROD1_W + INV_W;           // times inverse focal length
   localparam int FRAC_W   = 28;
   localparam int SHIFT_W  = PROD2_W - FRAC_W;

   localparam int DPB_GRID_STEP = 3;

   localparam logic [DEPTH_W-1:0] DEPTH_MIN_MM   = 16'd100;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX_RESET = 16'd10000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_MAX  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRINCIPAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INV_FY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PALLET_ID  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RAMP_ID    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TRAILER_ID = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GOODS_ID   = 3'd7;

   typedef enum logic [LABEL_W-1:0] {
      LABEL_NONE    = 3'd0,
      LABEL_PALLET  = 3'd1,
      LABEL_RAMP    = 3'd2,
      LABEL_TRAILER = 3'd3,
      LABEL_GOODS   = 3'd4
   } label_type;

endpackage

`default_nettype wire

// File: src/depth_pixel_backprojection.sv
`timescale 1ns / 1ps
`default_nettype none

// depth pixel back-projection, pinhole camera model
//
// input channel: a pixel word (column, row, depth, raw class id) is taken at
// every rising edge with start high; busy never rises, so one pixel per clock
// is sustained with no gaps.
// result channel: a point word (forward, left, up, label) sits on the rsp_
// ports for one cycle with rsp_valid high. pixels off the sampling grid or
// outside the depth window give no word, and their slot stays empty.
// the point is registered in stages 1, 2, 3 and 4 in turn on its way to the rsp_ ports.
// throughput: one pixel per cycle, set by the four-stage pipeline (one
// 17x16 and one 33x24 multiply per axis, each in a stage of its own).
// the receiver cannot stall, so nothing is ever held back.
// configuration: csr_we writes csr_wdata into register csr_index at a rising
// edge; write only while no pixel is in flight.
// reset (synchronous, active high) empties the pipeline and restores the
// register defaults (depth limit 10000 mm, everything else zero).

module depth_pixel_backprojection
   import dpb_pkg::*;
#(
   parameter int GRID_STEP = DPB_GRID_STEP
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // pixel input
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [PIX_W-1:0]             req_pixel_col,
   input  wire logic [PIX_W-1:0]             req_pixel_row,
   input  wire logic [DEPTH_W-1:0]           req_depth_mm,
   input  wire logic [CLASS_W-1:0]           req_class_id,
   // point output
   output logic                              rsp_valid,
   output logic [DEPTH_W-1:0]                rsp_forward_mm,
   output logic signed [COORD_W-1:0]         rsp_left_mm,
   output logic signed [COORD_W-1:0]         rsp_up_mm,
   output logic [LABEL_W-1:0]                rsp_label,
   // configuration
   input  wire logic                         csr_we,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   // grid test by reciprocal multiply: q = floor(n / GRID_STEP) exactly for
   // 12-bit n since the rounding error stays below 1/16
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** RECIP_SHIFT + GRID_STEP - 1) / GRID_STEP);
   localparam int QPROD_W = PIX_W + RECIP_W;
   localparam int STEP_W  = 4;
   localparam logic [STEP_W-1:0] STEP_C = STEP_W'(GRID_STEP);
   localparam int MULQ_W  = PIX_W + STEP_W;

   localparam logic signed [SHIFT_W-1:0] COORD_MAX_S = SHIFT_W'(1048575);
   localparam logic signed [SHIFT_W-1:0] COORD_MIN_S = -SHIFT_W'(1048576);
   localparam logic signed [COORD_W-1:0] COORD_MAX   = COORD_W'(1048575);
   localparam logic signed [COORD_W-1:0] COORD_MIN   = -COORD_W'(1048576);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [DEPTH_W-1:0]    depth_max_ff;
   logic [CSR_DATA_W-1:0] principal_ff;
   logic [INV_W-1:0]      inv_fx_ff;
   logic [INV_W-1:0]      inv_fy_ff;
   logic [CLASS_W-1:0]    pallet_id_ff;
   logic [CLASS_W-1:0]    ramp_id_ff;
   logic [CLASS_W-1:0]    trailer_id_ff;
   logic [CLASS_W-1:0]    goods_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_max_ff  <= DEPTH_MAX_RESET;
         principal_ff  <= '0;
         inv_fx_ff     <= '0;
         inv_fy_ff     <= '0;
         pallet_id_ff  <= '0;
         ramp_id_ff    <= '0;
         trailer_id_ff <= '0;
         goods_id_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DEPTH_MAX:  depth_max_ff  <= csr_wdata[DEPTH_W-1:0];
            REG_PRINCIPAL:  principal_ff  <= csr_wdata;
            REG_INV_FX:     inv_fx_ff     <= csr_wdata[INV_W-1:0];
            REG_INV_FY:     inv_fy_ff     <= csr_wdata[INV_W-1:0];
            REG_PALLET_ID:  pallet_id_ff  <= csr_wdata[CLASS_W-1:0];
            REG_RAMP_ID:    ramp_id_ff    <= csr_wdata[CLASS_W-1:0];
            REG_TRAILER_ID: trailer_id_ff <= csr_wdata[CLASS_W-1:0];
            REG_GOODS_ID:   goods_id_ff   <= csr_wdata[CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   // no back-pressure on the input side
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // stage 1: centre offsets, grid quotients, depth window, class remap
   // ---------------------------------------------------------------
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [DIFF_W-1:0]  s1_dx_ff, s1_dx_in;
   logic signed [DIFF_W-1:0]  s1_dy_ff, s1_dy_in;
   logic [DEPTH_W-1:0]        s1_depth_ff;
   logic [PIX_W-1:0]          s1_col_ff, s1_row_ff;
   logic [PIX_W-1:0]          s1_qcol_ff, s1_qcol_in;
   logic [PIX_W-1:0]          s1_qrow_ff, s1_qrow_in;
   logic                      s1_depth_ok_ff, s1_depth_ok_in;
   label_type                 s1_label_ff, s1_label_in;
   logic [QPROD_W-1:0]        qcol_prod, qrow_prod;

   always_comb begin
      s1_valid_in = start & ~busy;
      s1_dx_in = $signed({1'b0, req_pixel_col, 4'b0000})
               - $signed({1'b0, principal_ff[CENTRE_W-1:0]});
      s1_dy_in = $signed({1'b0, req_pixel_row, 4'b0000})
               - $signed({1'b0, principal_ff[CSR_DATA_W-1:CENTRE_W]});
      qcol_prod  = QPROD_W'(req_pixel_col) * QPROD_W'(RECIP);
      qrow_prod  = QPROD_W'(req_pixel_row) * QPROD_W'(RECIP);
      s1_qcol_in = qcol_prod[RECIP_SHIFT +: PIX_W];
      s1_qrow_in = qrow_prod[RECIP_SHIFT +: PIX_W];
      s1_depth_ok_in = (req_depth_mm > DEPTH_MIN_MM) && (req_depth_mm < depth_max_ff);
      // raw zero wins first, then the ids in priority order
      if (req_class_id == '0)                 s1_label_in = LABEL_NONE;
      else if (req_class_id == pallet_id_ff)  s1_label_in = LABEL_PALLET;
      else if (req_class_id == ramp_id_ff)    s1_label_in = LABEL_RAMP;
      else if (req_class_id == trailer_id_ff) s1_label_in = LABEL_TRAILER;
      else if (req_class_id == goods_id_ff)   s1_label_in = LABEL_GOODS;
      else                                    s1_label_in = LABEL_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_dx_ff       <= s1_dx_in;
      s1_dy_ff       <= s1_dy_in;
      s1_depth_ff    <= req_depth_mm;
      s1_col_ff      <= req_pixel_col;
      s1_row_ff      <= req_pixel_row;
      s1_qcol_ff     <= s1_qcol_in;
      s1_qrow_ff     <= s1_qrow_in;
      s1_depth_ok_ff <= s1_depth_ok_in;
      s1_label_ff    <= s1_label_in;
   end

   // ---------------------------------------------------------------
   // stage 2: offset times depth, grid check closes the keep flag
   // ---------------------------------------------------------------
   logic                      s2_valid_ff, s2_valid_in;
   logic signed [PROD1_W-1:0] s2_px_ff, s2_px_in;
   logic signed [PROD1_W-1:0] s2_py_ff, s2_py_in;
   logic [DEPTH_W-1:0]        s2_depth_ff;
   label_type                 s2_label_ff;
   logic [MULQ_W-1:0]         col_back, row_back;
   logic                      grid_ok;
   logic signed [PROD1_W-1:0] depth_s1;

   always_comb begin
      col_back = MULQ_W'(s1_qcol_ff) * MULQ_W'(STEP_C);
      row_back = MULQ_W'(s1_qrow_ff) * MULQ_W'(STEP_C);
      grid_ok  = (col_back == MULQ_W'(s1_col_ff)) && (row_back == MULQ_W'(s1_row_ff));
      s2_valid_in = s1_valid_ff & s1_depth_ok_ff & grid_ok;
      depth_s1 = $signed(PROD1_W'(s1_depth_ff));
      s2_px_in = PROD1_W'(s1_dx_ff) * depth_s1;
      s2_py_in = PROD1_W'(s1_dy_ff) * depth_s1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_px_ff    <= s2_px_in;
      s2_py_ff    <= s2_py_in;
      s2_depth_ff <= s1_depth_ff;
      s2_label_ff <= s1_label_ff;
   end

   // ---------------------------------------------------------------
   // stage 3: times inverse focal length
   // ---------------------------------------------------------------
   logic                      s3_valid_ff;
   logic signed [PROD2_W-1:0] s3_px_ff, s3_px_in;
   logic signed [PROD2_W-1:0] s3_py_ff, s3_py_in;
   logic [DEPTH_W-1:0]        s3_depth_ff;
   label_type                 s3_label_ff;

   always_comb begin
      s3_px_in = PROD2_W'(s2_px_ff) * $signed(PROD2_W'(inv_fx_ff));
      s3_py_in = PROD2_W'(s2_py_ff) * $signed(PROD2_W'(inv_fy_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_px_ff    <= s3_px_in;
      s3_py_ff    <= s3_py_in;
      s3_depth_ff <= s2_depth_ff;
      s3_label_ff <= s2_label_ff;
   end

   // ---------------------------------------------------------------
   // stage 4: floor shift, clamp, negate, clamp again into the outputs
   // ---------------------------------------------------------------
   // the upper bits of the product are the floor of p / 2^28
   function automatic logic signed [COORD_W-1:0] neg_sat(input logic signed [SHIFT_W-1:0] s);
      logic signed [SHIFT_W-1:0] n;
      n = -s;
      if (s > COORD_MAX_S)       neg_sat = -COORD_MAX;
      else if (s <= COORD_MIN_S) neg_sat = COORD_MAX;   // -min does not fit
      else                       neg_sat = n[COORD_W-1:0];
   endfunction

   logic                      out_valid_ff;
   logic [DEPTH_W-1:0]        out_forward_ff;
   logic signed [COORD_W-1:0] out_left_ff, out_left_in;
   logic signed [COORD_W-1:0] out_up_ff, out_up_in;
   label_type                 out_label_ff;

   always_comb begin
      out_left_in = neg_sat(s3_px_ff[PROD2_W-1:FRAC_W]);
      out_up_in   = neg_sat(s3_py_ff[PROD2_W-1:FRAC_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s3_valid_ff;
      end
      out_forward_ff <= s3_depth_ff;
      out_left_ff    <= out_left_in;
      out_up_ff      <= out_up_in;
      out_label_ff   <= s3_label_ff;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_forward_mm = out_forward_ff;
   assign rsp_left_mm    = out_left_ff;
   assign rsp_up_mm      = out_up_ff;
   assign rsp_label      = out_label_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // every point word goes back to an accepted pixel
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("point word without an accepted pixel");

   // a point always lies inside the depth window
   a_rsp_depth_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_forward_mm > DEPTH_MIN_MM) && (rsp_forward_mm < depth_max_ff))
      else $error("point depth outside the window");

   // the negated clamp never yields the most negative code
   a_rsp_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_mm != COORD_MIN) && (rsp_up_mm != COORD_MIN))
      else $error("negated coordinate hit the lower bound");

endmodule

`default_nettype wire
